### hdl/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types and constants for the link supervisor: link states, event
// codes, action codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

    localparam int DEF_TIME_BITS = 32;

    localparam int MODE_W   = 3;
    localparam int NOW_W    = 32;
    localparam int ACTION_W = 4;
    localparam int STATE_W  = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_ACTS = 4;
    localparam int CNT_W    = 3;

    localparam int S_DATA_W = 40;   // mode + now_ms = 35 bits, padded to bytes
    localparam int M_DATA_W = 8;    // action + link_state = 6 bits, padded

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE       = 2'd0,
        ST_CONNECTING = 2'd1,
        ST_CONNECTED  = 2'd2,
        ST_STREAMING  = 2'd3
    } link_state_t;

    typedef enum logic [MODE_W-1:0] {
        EV_NONE         = 3'd0,
        EV_CONNECT      = 3'd1,
        EV_START        = 3'd2,
        EV_STOP         = 3'd3,
        EV_READY_RX     = 3'd4,
        EV_HEARTBEAT_RX = 3'd5,
        EV_DATA_RX      = 3'd6
    } event_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_HELLO            = 4'd0,
        ACT_START            = 4'd1,
        ACT_STOP             = 4'd2,
        ACT_HEARTBEAT        = 4'd3,
        ACT_REP_CONNECTING   = 4'd4,
        ACT_REP_READY        = 4'd5,
        ACT_REP_STREAMING    = 4'd6,
        ACT_REP_CONNECTED    = 4'd7,
        ACT_REP_DISCONNECTED = 4'd8
    } action_t;

    localparam logic [CFG_IDX_W-1:0] REG_HELLO_RETRY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONN_REPORT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEER_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READY_BEACON = 3'd4;

    localparam logic [CFG_W-1:0] RST_HELLO_RETRY  = 16'd500;
    localparam logic [CFG_W-1:0] RST_CONN_REPORT  = 16'd1000;
    localparam logic [CFG_W-1:0] RST_HEARTBEAT    = 16'd1000;
    localparam logic [CFG_W-1:0] RST_PEER_TIMEOUT = 16'd3000;
    localparam logic [CFG_W-1:0] RST_READY_BEACON = 16'd2000;

endpackage

`default_nettype wire

### hdl/link_supervisor_fsm.sv
// ----------------------------------------------------------------------------
// link_supervisor_fsm
// Four-state link supervisor. Applies one event per transfer, runs the
// periodic hello, report, heartbeat, timeout and beacon checks, and emits
// the resulting actions one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_*      | in        | tdata: mode[2:0], now_ms[34:3]
//  m_*      | out       | tdata: action[3:0], link_state[5:4]; tlast: last
//  cfg_*    | in        | cfg_index selects register, cfg_data 16-bit value
//
//  An input transfer is decoded in the cycle it is taken; its 0..4 actions
//  sit in the result buffer and leave at one per cycle while m_tready is
//  high. A new input is taken when the buffer is empty or its final action
//  is being taken in the same cycle. Synchronous active-low reset;
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module link_supervisor_fsm #(
    parameter int TIME_BITS = lsf_pkg::DEF_TIME_BITS
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [lsf_pkg::S_DATA_W-1:0]     s_tdata,   // mode[2:0], now_ms[34:3]
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [lsf_pkg::M_DATA_W-1:0]     m_tdata,   // action[3:0], link_state[5:4]
    output logic                             m_tlast,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [lsf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [lsf_pkg::CFG_W-1:0]        cfg_data
);

    typedef logic [TIME_BITS-1:0] time_t;

    // configuration
    logic [lsf_pkg::CFG_W-1:0] hello_retry_reg, conn_report_reg, heartbeat_reg;
    logic [lsf_pkg::CFG_W-1:0] peer_timeout_reg, ready_beacon_reg;

    // supervisor state
    lsf_pkg::link_state_t state_reg, state_next, ev_state;
    time_t hello_reg, report_reg, hb_reg, peer_reg, beacon_reg;
    time_t hello_next, report_next, hb_next, peer_next, beacon_next;
    time_t hello_base, report_base;

    // result buffer
    lsf_pkg::action_t                   acts_reg [lsf_pkg::MAX_ACTS];
    lsf_pkg::action_t                   acts_next [lsf_pkg::MAX_ACTS];
    logic [lsf_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    lsf_pkg::link_state_t               out_state_reg;

    // decode
    lsf_pkg::event_t                    ev;
    time_t                              now;
    lsf_pkg::action_t                   ev_act [2];
    logic [1:0]                         ev_n;
    logic hello_fire, report_fire, hb_fire, timeout_fire, beacon_fire;
    logic s_fire, m_fire;

    assign ev  = lsf_pkg::event_t'(s_tdata[lsf_pkg::MODE_W-1:0]);
    assign now = TIME_BITS'(s_tdata[lsf_pkg::MODE_W +: lsf_pkg::NOW_W]);

    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid & s_tready;
    assign m_fire    = m_tvalid & m_tready;
    assign s_tready  = (cnt_reg == '0) || (m_fire && (cnt_reg == lsf_pkg::CNT_W'(1)));

    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == lsf_pkg::CNT_W'(1));
    assign m_tdata  = {2'b00, out_state_reg, acts_reg[0]};

    // event phase
    always_comb begin
        ev_state    = state_reg;
        ev_n        = 2'd0;
        ev_act[0]   = lsf_pkg::ACT_HELLO;
        ev_act[1]   = lsf_pkg::ACT_HELLO;
        peer_next   = peer_reg;
        hello_base  = hello_reg;
        report_base = report_reg;
        unique case (ev)
            lsf_pkg::EV_CONNECT: begin
                if (state_reg == lsf_pkg::ST_IDLE) begin
                    ev_state    = lsf_pkg::ST_CONNECTING;
                    hello_base  = '0;
                    report_base = '0;
                    ev_act[0]   = lsf_pkg::ACT_REP_CONNECTING;
                    ev_n        = 2'd1;
                end
            end
            lsf_pkg::EV_START: begin
                if (state_reg == lsf_pkg::ST_CONNECTED) begin
                    ev_state  = lsf_pkg::ST_STREAMING;
                    ev_act[0] = lsf_pkg::ACT_START;
                    ev_act[1] = lsf_pkg::ACT_REP_STREAMING;
                    ev_n      = 2'd2;
                end
            end
            lsf_pkg::EV_STOP: begin
                if (state_reg == lsf_pkg::ST_STREAMING) begin
                    ev_state  = lsf_pkg::ST_CONNECTED;
                    ev_act[0] = lsf_pkg::ACT_STOP;
                    ev_act[1] = lsf_pkg::ACT_REP_CONNECTED;
                    ev_n      = 2'd2;
                end else if (state_reg == lsf_pkg::ST_CONNECTING) begin
                    ev_state  = lsf_pkg::ST_IDLE;
                    ev_act[0] = lsf_pkg::ACT_REP_READY;
                    ev_n      = 2'd1;
                end
            end
            lsf_pkg::EV_READY_RX: begin
                peer_next = now;
                if (state_reg == lsf_pkg::ST_CONNECTING) begin
                    ev_state  = lsf_pkg::ST_CONNECTED;
                    ev_act[0] = lsf_pkg::ACT_REP_CONNECTED;
                    ev_n      = 2'd1;
                end
            end
            lsf_pkg::EV_HEARTBEAT_RX,
            lsf_pkg::EV_DATA_RX: begin
                peer_next = now;
            end
            default: begin
            end
        endcase
    end

    // periodic checks and next state
    always_comb begin
        logic conn, linked;
        conn   = (ev_state == lsf_pkg::ST_CONNECTING);
        linked = (ev_state == lsf_pkg::ST_CONNECTED) || (ev_state == lsf_pkg::ST_STREAMING);

        hello_fire   = conn && (time_t'(now - hello_base) >= TIME_BITS'(hello_retry_reg));
        report_fire  = conn && (time_t'(now - report_base) >= TIME_BITS'(conn_report_reg));
        hb_fire      = linked && (time_t'(now - hb_reg) >= TIME_BITS'(heartbeat_reg));
        timeout_fire = linked && (peer_next != '0)
                       && (time_t'(now - peer_next) > TIME_BITS'(peer_timeout_reg));
        beacon_fire  = (ev_state == lsf_pkg::ST_IDLE)
                       && (time_t'(now - beacon_reg) >= TIME_BITS'(ready_beacon_reg));

        state_next  = timeout_fire ? lsf_pkg::ST_IDLE : ev_state;
        hello_next  = hello_fire  ? now : hello_base;
        report_next = report_fire ? now : report_base;
        hb_next     = hb_fire     ? now : hb_reg;
        beacon_next = beacon_fire ? now : beacon_reg;
    end

    // action list
    always_comb begin
        logic [lsf_pkg::CNT_W-1:0] n;
        logic                      push [5];
        lsf_pkg::action_t          code [5];
        for (int i = 0; i < lsf_pkg::MAX_ACTS; i++) begin
            acts_next[i] = lsf_pkg::ACT_HELLO;
        end
        n = lsf_pkg::CNT_W'(ev_n);
        acts_next[0] = ev_act[0];
        acts_next[1] = ev_act[1];
        push[0] = hello_fire;   code[0] = lsf_pkg::ACT_HELLO;
        push[1] = report_fire;  code[1] = lsf_pkg::ACT_REP_CONNECTING;
        push[2] = hb_fire;      code[2] = lsf_pkg::ACT_HEARTBEAT;
        push[3] = timeout_fire; code[3] = lsf_pkg::ACT_REP_DISCONNECTED;
        push[4] = beacon_fire;  code[4] = lsf_pkg::ACT_REP_READY;
        for (int k = 0; k < 5; k++) begin
            if (push[k] && (n < lsf_pkg::CNT_W'(lsf_pkg::MAX_ACTS))) begin
                acts_next[n[1:0]] = code[k];
                n = n + lsf_pkg::CNT_W'(1);
            end
        end
        cnt_next = n;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hello_retry_reg  <= lsf_pkg::RST_HELLO_RETRY;
            conn_report_reg  <= lsf_pkg::RST_CONN_REPORT;
            heartbeat_reg    <= lsf_pkg::RST_HEARTBEAT;
            peer_timeout_reg <= lsf_pkg::RST_PEER_TIMEOUT;
            ready_beacon_reg <= lsf_pkg::RST_READY_BEACON;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lsf_pkg::REG_HELLO_RETRY:  hello_retry_reg  <= cfg_data;
                lsf_pkg::REG_CONN_REPORT:  conn_report_reg  <= cfg_data;
                lsf_pkg::REG_HEARTBEAT:    heartbeat_reg    <= cfg_data;
                lsf_pkg::REG_PEER_TIMEOUT: peer_timeout_reg <= cfg_data;
                lsf_pkg::REG_READY_BEACON: ready_beacon_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // supervisor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= lsf_pkg::ST_IDLE;
            hello_reg  <= '0;
            report_reg <= '0;
            hb_reg     <= '0;
            peer_reg   <= '0;
            beacon_reg <= '0;
        end else if (s_fire) begin
            state_reg  <= state_next;
            hello_reg  <= hello_next;
            report_reg <= report_next;
            hb_reg     <= hb_next;
            peer_reg   <= peer_next;
            beacon_reg <= beacon_next;
        end
    end

    // result buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (s_fire) begin
            cnt_reg <= cnt_next;
        end else if (m_fire) begin
            cnt_reg <= cnt_reg - lsf_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_state_reg <= state_next;
            for (int i = 0; i < lsf_pkg::MAX_ACTS; i++) begin
                acts_reg[i] <= acts_next[i];
            end
        end else if (m_fire) begin
            for (int i = 0; i < lsf_pkg::MAX_ACTS - 1; i++) begin
                acts_reg[i] <= acts_reg[i+1];
            end
        end
    end

endmodule

`default_nettype wire

### hdl/lsf_checker.sv
// ----------------------------------------------------------------------------
// lsf_checker
// Port-level checks for the link supervisor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tready,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [lsf_pkg::M_DATA_W-1:0]   m_tdata,
    input wire                           m_tlast
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // input is only held off while results are pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty result buffer");

    // all actions of one item carry the same link state
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[5:4] == $past(m_tdata[5:4])))
        else $error("link state changed within an item");

    // a disconnect report closes the item and leaves the link idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:0] == lsf_pkg::ACT_REP_DISCONNECTED) |->
            m_tlast && (m_tdata[5:4] == lsf_pkg::ST_IDLE))
        else $error("disconnect report not final or not idle");

    // buffer empty after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind link_supervisor_fsm lsf_checker u_lsf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for link_supervisor_fsm. Event/timestamp items are
// streamed in with random gaps while results are drained with random
// back-pressure. A behavioural copy of the supervisor predicts the action list
// for every accepted item and each result transfer is checked in order.
// Covers all event codes, clock wrap, the peer-at-zero case, spare register
// indexes and interval registers at zero, one and full scale.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SHOW_LIMIT    = 10;

    localparam logic [MODE_W-1:0]    EV_RESERVED     = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SPARE = REG_READY_BEACON + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_SPARE  = {CFG_IDX_W{1'b1}};

    typedef struct {
        action_t     action;
        link_state_t state;
        logic        last;
    } link_action_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;    // mode[2:0], now_ms[34:3]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // action[3:0], link_state[5:4]
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    link_supervisor_fsm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // supervisor copy
    logic [CFG_W-1:0] hello_gap   = RST_HELLO_RETRY;
    logic [CFG_W-1:0] report_gap  = RST_CONN_REPORT;
    logic [CFG_W-1:0] hb_gap      = RST_HEARTBEAT;
    logic [CFG_W-1:0] peer_limit  = RST_PEER_TIMEOUT;
    logic [CFG_W-1:0] beacon_gap  = RST_READY_BEACON;
    link_state_t      link_mode   = ST_IDLE;
    logic [NOW_W-1:0] hello_at    = '0;
    logic [NOW_W-1:0] report_at   = '0;
    logic [NOW_W-1:0] hb_at       = '0;
    logic [NOW_W-1:0] peer_at     = '0;
    logic [NOW_W-1:0] beacon_at   = '0;

    link_action_t     pending_actions[$];
    int               mismatches = 0;
    int               cycles = 0;
    bit               steady_flow = 1'b0;
    logic [NOW_W-1:0] wall_ms = '0;

    function automatic logic [NOW_W-1:0] since(input logic [NOW_W-1:0] now,
                                               input logic [NOW_W-1:0] then);
        return now - then;
    endfunction

    function automatic void advance_link(input logic [MODE_W-1:0] ev,
                                         input logic [NOW_W-1:0] now);
        action_t      acts[$];
        link_action_t item;
        case (ev)
            EV_CONNECT: if (link_mode == ST_IDLE) begin
                link_mode = ST_CONNECTING;
                hello_at  = '0;
                report_at = '0;
                acts.push_back(ACT_REP_CONNECTING);
            end
            EV_START: if (link_mode == ST_CONNECTED) begin
                acts.push_back(ACT_START);
                link_mode = ST_STREAMING;
                acts.push_back(ACT_REP_STREAMING);
            end
            EV_STOP: begin
                if (link_mode == ST_STREAMING) begin
                    acts.push_back(ACT_STOP);
                    link_mode = ST_CONNECTED;
                    acts.push_back(ACT_REP_CONNECTED);
                end else if (link_mode == ST_CONNECTING) begin
                    link_mode = ST_IDLE;
                    acts.push_back(ACT_REP_READY);
                end
            end
            EV_READY_RX: begin
                peer_at = now;
                if (link_mode == ST_CONNECTING) begin
                    link_mode = ST_CONNECTED;
                    acts.push_back(ACT_REP_CONNECTED);
                end
            end
            EV_HEARTBEAT_RX, EV_DATA_RX: peer_at = now;
            default: ;
        endcase

        case (link_mode)
            ST_CONNECTING: begin
                if (since(now, hello_at) >= hello_gap) begin
                    acts.push_back(ACT_HELLO);
                    hello_at = now;
                end
                if (since(now, report_at) >= report_gap) begin
                    acts.push_back(ACT_REP_CONNECTING);
                    report_at = now;
                end
            end
            ST_CONNECTED, ST_STREAMING: begin
                if (since(now, hb_at) >= hb_gap) begin
                    acts.push_back(ACT_HEARTBEAT);
                    hb_at = now;
                end
                // peer time of zero reads as never seen
                if (peer_at != '0 && since(now, peer_at) > peer_limit) begin
                    link_mode = ST_IDLE;
                    acts.push_back(ACT_REP_DISCONNECTED);
                end
            end
            default: begin
                if (since(now, beacon_at) >= beacon_gap) begin
                    acts.push_back(ACT_REP_READY);
                    beacon_at = now;
                end
            end
        endcase

        foreach (acts[k]) begin
            item.action = acts[k];
            item.state  = link_mode;
            item.last   = (k == acts.size() - 1);
            pending_actions.push_back(item);
        end
    endfunction

    function automatic void load_interval(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
        case (idx)
            REG_HELLO_RETRY:  hello_gap  = val;
            REG_CONN_REPORT:  report_gap = val;
            REG_HEARTBEAT:    hb_gap     = val;
            REG_PEER_TIMEOUT: peer_limit = val;
            REG_READY_BEACON: beacon_gap = val;
            default: ;
        endcase
    endfunction

    // prediction, result checking and run limit
    always @(posedge aclk) begin
        link_action_t exp_act;
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end else if (aresetn) begin
            if (cfg_valid && cfg_ready)
                load_interval(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                advance_link(s_tdata[MODE_W-1:0], s_tdata[MODE_W +: NOW_W]);
            if (m_tvalid && m_tready) begin
                if (pending_actions.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("unexpected transfer: action %0d state %0d last %0b",
                                 m_tdata[3:0], m_tdata[5:4], m_tlast);
                end else begin
                    exp_act = pending_actions.pop_front();
                    if (m_tdata[3:0] !== exp_act.action || m_tdata[5:4] !== exp_act.state
                            || m_tlast !== exp_act.last) begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT)
                            $display("mismatch: exp action %0d state %0d last %0b, %s %0d %0d %0b",
                                     exp_act.action, exp_act.state, exp_act.last, "got",
                                     m_tdata[3:0], m_tdata[5:4], m_tlast);
                    end
                end
            end
        end
    end

    function automatic int idle_cycles();
        return steady_flow ? 0 : $urandom_range(0, 11);
    endfunction

    // result back-pressure
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    task automatic send_event(input logic [MODE_W-1:0] ev, input logic [NOW_W-1:0] now);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {{(S_DATA_W - MODE_W - NOW_W){1'b0}}, now, ev};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_link_quiet();
        s_tvalid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_all_regs(input logic [CFG_W-1:0] val);
        write_reg(REG_HELLO_RETRY, val);
        write_reg(REG_CONN_REPORT, val);
        write_reg(REG_HEARTBEAT, val);
        write_reg(REG_PEER_TIMEOUT, val);
        write_reg(REG_READY_BEACON, val);
    endtask

    function automatic logic [CFG_W-1:0] pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return CFG_W'(1);
        else if (r < 15)
            return '1;
        else if (r < 20)
            return '0;
        else
            return CFG_W'($urandom_range(1, 3000));
    endfunction

    // mostly the next step of a normal session, driven by the predicted state
    function automatic logic [MODE_W-1:0] session_event();
        int r;
        r = $urandom_range(0, 99);
        case (link_mode)
            ST_IDLE:       return (r < 70) ? EV_CONNECT : EV_NONE;
            ST_CONNECTING: return (r < 60) ? EV_READY_RX : (r < 75) ? EV_STOP : EV_NONE;
            ST_CONNECTED:  return (r < 35) ? EV_START : (r < 70) ? EV_HEARTBEAT_RX :
                                  (r < 85) ? EV_DATA_RX : EV_NONE;
            default:       return (r < 45) ? EV_DATA_RX : (r < 70) ? EV_HEARTBEAT_RX :
                                  (r < 85) ? EV_STOP : EV_NONE;
        endcase
    endfunction

    task automatic run_session(input int count, input int step_hi);
        logic [MODE_W-1:0] ev;
        int                r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            ev = (r < 78) ? session_event() : MODE_W'($urandom_range(0, 7));
            r = $urandom_range(0, 99);
            if (r < 82)
                wall_ms += $urandom_range(0, step_hi);
            else if (r < 94)
                wall_ms += $urandom_range(0, 70000);
            else
                wall_ms = $urandom;
            send_event(ev, wall_ms);
        end
    endtask

    task automatic test_directed_events();
        send_event(EV_NONE, 32'd0);
        send_event(EV_NONE, 32'd2000);
        send_event(EV_STOP, 32'd2100);
        send_event(EV_CONNECT, 32'd2200);
        send_event(EV_START, 32'd2300);
        send_event(EV_RESERVED, 32'd2700);
        send_event(EV_STOP, 32'd2800);
        send_event(EV_CONNECT, 32'd3000);
        send_event(EV_READY_RX, 32'd3100);
        send_event(EV_START, 32'd3200);
        send_event(EV_DATA_RX, 32'd3300);
        send_event(EV_HEARTBEAT_RX, 32'd4200);
        send_event(EV_CONNECT, 32'd4300);
        send_event(EV_STOP, 32'd4400);
        send_event(EV_STOP, 32'd4500);
        send_event(EV_START, 32'd7300);
        send_event(EV_NONE, 32'hFFFF_FF00);
        send_event(EV_CONNECT, 32'hFFFF_FFFF);
        // peer seen at zero leaves the timeout unarmed
        send_event(EV_READY_RX, 32'd0);
        send_event(EV_NONE, 32'h0001_0000);
        send_event(EV_HEARTBEAT_RX, 32'h7FFF_FFFF);
        send_event(EV_NONE, 32'h7FFF_FFFF + 32'd3001);
        wait_link_quiet();
    endtask

    task automatic test_register_extremes();
        write_all_regs('1);
        wall_ms = 32'hFFFF_0000;
        run_session(20, 20000);
        wait_link_quiet();
        write_all_regs(CFG_W'(1));
        run_session(20, 3);
        wait_link_quiet();
        write_all_regs('0);
        run_session(20, 2);
        wait_link_quiet();
        // spare indexes must leave every interval alone
        for (int i = REG_FIRST_SPARE; i <= REG_LAST_SPARE; i++)
            write_reg(CFG_IDX_W'(i), CFG_W'($urandom));
        run_session(15, 2);
        wait_link_quiet();
    endtask

    task automatic test_random_sessions();
        for (int phase = 0; phase < 8; phase++) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            write_reg(REG_HELLO_RETRY, pick_interval());
            write_reg(REG_CONN_REPORT, pick_interval());
            write_reg(REG_HEARTBEAT, pick_interval());
            write_reg(REG_PEER_TIMEOUT, pick_interval());
            write_reg(REG_READY_BEACON, pick_interval());
            run_session(25, $urandom_range(20, 1500));
            // hold the sender until the link has gone quiet
            wait_link_quiet();
            run_session(25, $urandom_range(20, 1500));
            wait_link_quiet();
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_events();
        test_register_extremes();
        test_random_sessions();
        wait_link_quiet();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
hdl/lsf_pkg.sv
hdl/link_supervisor_fsm.sv
hdl/lsf_checker.sv
tb/sv/tb_top.sv
